FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/lfb_pkg.sv
// ----------------------------------------------------------------------------
// LED feedback blink renderer package
// Colour type, code band limits, blink bits and the fixed palette.
// ----------------------------------------------------------------------------
package lfb_pkg;

  typedef struct packed {
    logic       write_pixel;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  localparam logic [7:0] STATIC_END  = 8'd14;
  localparam logic [7:0] FAST_END    = 8'd27;
  localparam logic [7:0] MIDDLE_END  = 8'd39;
  localparam logic [7:0] SLOW_END    = 8'd51;
  localparam logic [7:0] FAST_BASE   = 8'd13;
  localparam logic [7:0] MIDDLE_BASE = 8'd26;
  localparam logic [7:0] SLOW_BASE   = 8'd38;

  localparam logic [4:0] PHASE_TOP   = 5'd16;
  localparam int unsigned FAST_BIT   = 1;
  localparam int unsigned MIDDLE_BIT = 2;
  localparam int unsigned SLOW_BIT   = 3;

  function automatic color_t palette(input logic [3:0] sel);
    color_t c;
    c.write_pixel = 1'b1;
    unique case (sel)
      4'd0:    {c.red, c.green, c.blue} = {8'h00, 8'h00, 8'h00};
      4'd1:    {c.red, c.green, c.blue} = {8'hff, 8'hff, 8'hff};
      4'd2:    {c.red, c.green, c.blue} = {8'hff, 8'h00, 8'h00};
      4'd3:    {c.red, c.green, c.blue} = {8'hff, 8'h80, 8'h00};
      4'd4:    {c.red, c.green, c.blue} = {8'hff, 8'hff, 8'h00};
      4'd5:    {c.red, c.green, c.blue} = {8'h80, 8'hff, 8'h00};
      4'd6:    {c.red, c.green, c.blue} = {8'h00, 8'haa, 8'h00};
      4'd7:    {c.red, c.green, c.blue} = {8'h00, 8'hff, 8'h80};
      4'd8:    {c.red, c.green, c.blue} = {8'h00, 8'hff, 8'hff};
      4'd9:    {c.red, c.green, c.blue} = {8'h00, 8'h80, 8'hff};
      4'd10:   {c.red, c.green, c.blue} = {8'h00, 8'h00, 8'hff};
      4'd11:   {c.red, c.green, c.blue} = {8'h80, 8'h00, 8'hff};
      4'd12:   {c.red, c.green, c.blue} = {8'hff, 8'h00, 8'hff};
      4'd13:   {c.red, c.green, c.blue} = {8'hff, 8'h00, 8'h80};
      default: {c.red, c.green, c.blue} = {8'h00, 8'h00, 8'h00};
    endcase
    return c;
  endfunction

endpackage

FILE: sv/lfb_color.sv
// ----------------------------------------------------------------------------
// LED feedback colour decoder
// Turns one feedback code and the blink phase into a pixel colour.
// ----------------------------------------------------------------------------
module lfb_color (
  input  logic [7:0]      code_i,
  input  logic [4:0]      phase_i,
  output lfb_pkg::color_t color_o
);

  logic [3:0]      pal_sel;
  logic            wr;
  lfb_pkg::color_t pal_color;

  always_comb begin
    pal_sel = '0;
    wr      = 1'b1;
    priority if (code_i < lfb_pkg::STATIC_END) begin
      pal_sel = code_i[3:0];
    end else if (code_i < lfb_pkg::FAST_END) begin
      pal_sel = phase_i[lfb_pkg::FAST_BIT] ? 4'(code_i - lfb_pkg::FAST_BASE) : 4'd0;
    end else if (code_i < lfb_pkg::MIDDLE_END) begin
      pal_sel = phase_i[lfb_pkg::MIDDLE_BIT] ? 4'(code_i - lfb_pkg::MIDDLE_BASE) : 4'd0;
    end else if (code_i < lfb_pkg::SLOW_END) begin
      pal_sel = phase_i[lfb_pkg::SLOW_BIT] ? 4'(code_i - lfb_pkg::SLOW_BASE) : 4'd0;
    end else begin
      wr = 1'b0;
    end
  end

  assign pal_color = lfb_pkg::palette(pal_sel);

  always_comb begin
    if (wr) begin
      color_o = pal_color;
    end else begin
      color_o = '0;
    end
  end

endmodule

FILE: sv/led_feedback_blink_renderer_unit.sv
// ----------------------------------------------------------------------------
// LED feedback blink renderer
// Stores per-button feedback codes and renders a frame of pixel colours.
// ----------------------------------------------------------------------------
// A store item (in_tuser low) writes one code; an index beyond the table
// is dropped. A frame tick (in_tuser high) walks the code table and emits
// one pixel per cycle while the output is not stalled. The table has a
// single read port and feeds one shared colour decoder. in_tready is low
// during the walk.
module led_feedback_blink_renderer_unit #(
  parameter int BUTTON_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // button_index[7:0], color_code[15:8]
  input  logic        in_tuser,  // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // pixel_index[4:0], red[12:5], green[20:13],
                                 // blue[28:21], zero fill[31:29]
  output logic        out_tuser, // write_pixel
  output logic        out_tlast
);

  `include "assert_macros.svh"

  localparam int IDX_W = $clog2(BUTTON_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUTTON_COUNT - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                    state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [4:0]              phase_r, phase_nxt;
  logic [7:0]              mem_r [BUTTON_COUNT];
  logic [BUTTON_COUNT-1:0] vld_r;
  logic [7:0]              rd_code_r;
  logic                    rd_vld_r;
  logic                    in_acc;
  logic                    wr_en;
  logic                    load;
  logic [7:0]              cur_code;
  logic [7:0]              idx_ext;
  logic [4:0]              pix_idx;
  lfb_pkg::color_t         color;
  logic                    out_valid_r, out_valid_nxt;
  logic [31:0]             out_data_r;
  logic                    out_user_r;
  logic                    out_last_r;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign wr_en     = in_acc && !in_tuser && (in_tdata[7:0] < 8'(BUTTON_COUNT));
  assign load      = (state_r == ST_WALK) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_acc && in_tuser) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (load) begin
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
            idx_nxt   = '0;
            phase_nxt = (phase_r == lfb_pkg::PHASE_TOP) ? 5'd0 : phase_r + 5'd1;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      phase_r <= '0;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
      if (wr_en) begin
        vld_r[in_tdata[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[in_tdata[IDX_W-1:0]] <= in_tdata[15:8];
    end
  end

  always_ff @(posedge clk) begin
    rd_code_r <= mem_r[idx_nxt];
    rd_vld_r  <= vld_r[idx_nxt];
  end

  assign cur_code = rd_vld_r ? rd_code_r : 8'd0;

  lfb_color u_color (
    .code_i  (cur_code),
    .phase_i (phase_r),
    .color_o (color)
  );

  assign idx_ext = 8'(idx_r);
  assign pix_idx = {idx_ext[4], idx_ext[2], idx_ext[3], idx_ext[1:0]};

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= {3'b000, color.blue, color.green, color.red, pix_idx};
      out_user_r <= color.write_pixel;
      out_last_r <= (idx_r == LAST_IDX);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  `ASSERT_CLK(a_tick_starts_walk, (in_tvalid && in_tready && in_tuser) |=> (state_r == ST_WALK && idx_r == '0), "frame tick did not start a walk at the first button")
  `ASSERT_CLK(a_last_ends_walk, (load && idx_r == LAST_IDX) |=> (state_r == ST_IDLE && out_tlast && out_tvalid), "last pixel did not end the walk")
  `ASSERT_CLK(a_pixel_low_bits, load |=> (out_tdata[1:0] == $past(idx_r[1:0])), "pixel position lost its low bits")
  `ASSERT_ALWAYS(a_phase_range, !rst_n || phase_r <= lfb_pkg::PHASE_TOP, "blink phase out of range")

endmodule
